// ===== rtl/wasm_pkg.sv =====
// Shared widths, command and status codes, and controller/datapath link types.
`timescale 1ns / 1ps
package wasm_pkg;

	localparam int NUM_SLOTS_DEF      = 8;
	localparam int ZONES_PER_SLOT_DEF = 4;

	localparam int CMD_W     = 3;
	localparam int SLOT_W    = 4;
	localparam int ZIDX_W    = 3;
	localparam int DAYS_W    = 7;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int ZCNT_W    = 3;
	localparam int ZID_W     = 8;
	localparam int DUR_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int DOW_W     = 3;
	localparam int STATUS_W  = 2;
	localparam int FSLOT_W   = 3;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HEADER = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ZONE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FIRED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

	typedef struct packed {
		logic latch;
		logic exec;
		logic scan_next;
		logic fire;
		logic zone_rd;
		logic zone_next;
		logic put_zone;
		logic put_single;
	} wasm_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic hit;
		logic scan_end;
		logic zone_last;
		logic out_free;
	} wasm_sts_t;

endpackage

// ===== rtl/wasm_item_if.sv =====
// Input item channel: valid/ready handshake and command payload.
`timescale 1ns / 1ps
interface wasm_item_if import wasm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [SLOT_W-1:0]   slot;
	logic [ZIDX_W-1:0]   zone_index;
	logic                enable;
	logic [DAYS_W-1:0]   day_mask;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [ZCNT_W-1:0]   zone_count;
	logic [ZID_W-1:0]    zone_id;
	logic [DUR_W-1:0]    duration_min;
	logic [STAMP_W-1:0]  minute_stamp;
	logic [DOW_W-1:0]    day_of_week;

	modport source (output valid, cmd, slot, zone_index, enable, day_mask, hour, minute,
		zone_count, zone_id, duration_min, minute_stamp, day_of_week, input ready);
	modport sink (input valid, cmd, slot, zone_index, enable, day_mask, hour, minute,
		zone_count, zone_id, duration_min, minute_stamp, day_of_week, output ready);
endinterface

// ===== rtl/wasm_result_if.sv =====
// Result channel: valid/ready handshake and result payload.
`timescale 1ns / 1ps
interface wasm_result_if import wasm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FSLOT_W-1:0]  fired_slot;
	logic [ZID_W-1:0]    out_zone_id;
	logic [DUR_W-1:0]    out_duration;
	logic                last;

	modport source (output valid, status, fired_slot, out_zone_id, out_duration, last,
		input ready);
	modport sink (input valid, status, fired_slot, out_zone_id, out_duration, last,
		output ready);
endinterface

// ===== rtl/wasm_ctrl.sv =====
// Sequencing state machine: accept, execute, slot scan and zone emission.
`timescale 1ns / 1ps
module wasm_ctrl import wasm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  wasm_sts_t sts,
	output wasm_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_ZRD  = 3'd3;
	localparam logic [2:0] S_ZOUT = 3'd4;
	localparam logic [2:0] S_PUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.is_tick ? S_SCAN : S_PUT;
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.fire = 1'b1;
					state_d  = S_ZRD;
				end else if (sts.scan_end) begin
					state_d = S_PUT;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_ZRD: begin
				cmd.zone_rd = 1'b1;
				state_d     = S_ZOUT;
			end
			S_ZOUT: begin
				if (sts.out_free) begin
					cmd.put_zone = 1'b1;
					if (sts.zone_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.zone_next = 1'b1;
						state_d       = S_ZRD;
					end
				end
			end
			S_PUT: begin
				if (sts.out_free) begin
					cmd.put_single = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/wasm_dp.sv =====
// Datapath: slot table, zone memory, stamps, scan and zone counters, output register.
`timescale 1ns / 1ps
module wasm_dp import wasm_pkg::*; #(
	parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
	parameter int ZONES_PER_SLOT = ZONES_PER_SLOT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	wasm_item_if.sink           item,
	wasm_result_if.source       res,
	input  wasm_cmd_t           cmd,
	output wasm_sts_t           sts
);
	localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ZDEPTH = NUM_SLOTS * ZONES_PER_SLOT;
	localparam int ZAW    = (ZDEPTH > 1) ? $clog2(ZDEPTH) : 1;

	// latched item
	logic [CMD_W-1:0]    cmd_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ZIDX_W-1:0]   zi_q;
	logic                en_q;
	logic [DAYS_W-1:0]   days_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [ZCNT_W-1:0]   cnt_q;
	logic [ZID_W-1:0]    zid_q;
	logic [DUR_W-1:0]    dur_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [DOW_W-1:0]    dow_q;

	// slot table
	logic                slot_en_q    [NUM_SLOTS];
	logic [DAYS_W-1:0]   slot_days_q  [NUM_SLOTS];
	logic [HOUR_W-1:0]   slot_hour_q  [NUM_SLOTS];
	logic [MINUTE_W-1:0] slot_min_q   [NUM_SLOTS];
	logic [ZCNT_W-1:0]   slot_zc_q    [NUM_SLOTS];
	logic [STAMP_W-1:0]  slot_stamp_q [NUM_SLOTS];

	// zone memory with per-entry valid bits
	logic [ZID_W-1:0]    zid_mem [ZDEPTH];
	logic [DUR_W-1:0]    dur_mem [ZDEPTH];
	logic [ZDEPTH-1:0]   zvld_q;
	logic [ZID_W-1:0]    rd_zid_q;
	logic [DUR_W-1:0]    rd_dur_q;
	logic                rd_vld_q;

	// scan and emission
	logic [SW-1:0]       scan_q;
	logic [SW-1:0]       fslot_q;
	logic [ZCNT_W-1:0]   n_q;
	logic [ZCNT_W-1:0]   z_q;

	// output register
	logic                res_valid_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [FSLOT_W-1:0]  res_slot_q;
	logic [ZID_W-1:0]    res_zid_q;
	logic [DUR_W-1:0]    res_dur_q;
	logic                res_last_q;

	logic                table_cmd;
	logic                slot_ok;
	logic                zone_ok;
	logic                rejected;
	logic                do_write;
	logic [SW-1:0]       si;
	logic [ZAW-1:0]      wbase;
	logic [ZAW-1:0]      waddr;
	logic [ZAW-1:0]      raddr;
	logic [DAYS_W:0]     day_vec;
	logic                day_hit;
	logic [ZCNT_W-1:0]   cnt_sat;
	logic [SLOT_W-1:0]   fslot_w;

	assign table_cmd = (cmd_q == CMD_HEADER) || (cmd_q == CMD_ZONE) ||
		(cmd_q == CMD_CLEAR) || (cmd_q == CMD_TOGGLE);
	assign slot_ok   = {1'b0, slot_q} < (SLOT_W + 1)'(NUM_SLOTS);
	assign zone_ok   = {1'b0, zi_q} < (ZIDX_W + 1)'(ZONES_PER_SLOT);
	assign rejected  = table_cmd && (!slot_ok || ((cmd_q == CMD_ZONE) && !zone_ok));
	assign do_write  = cmd.exec && table_cmd && !rejected;
	assign si        = slot_q[SW-1:0];
	assign wbase     = ZAW'(si) * ZAW'(ZONES_PER_SLOT);
	assign waddr     = wbase + ZAW'(zi_q);
	assign raddr     = ZAW'(fslot_q) * ZAW'(ZONES_PER_SLOT) + ZAW'(z_q);
	assign cnt_sat   = ({1'b0, cnt_q} > (ZCNT_W + 1)'(ZONES_PER_SLOT)) ?
		ZCNT_W'(ZONES_PER_SLOT) : cnt_q;
	assign fslot_w   = SLOT_W'(fslot_q);

	assign day_vec = {1'b0, slot_days_q[scan_q]} >> dow_q;
	assign day_hit = (dow_q <= DOW_W'(6)) && day_vec[0];

	assign sts.is_tick   = (cmd_q == CMD_TICK);
	assign sts.hit       = slot_en_q[scan_q] && (slot_zc_q[scan_q] != '0) && day_hit &&
		(slot_hour_q[scan_q] == hour_q) && (slot_min_q[scan_q] == minute_q) &&
		(slot_stamp_q[scan_q] != stamp_q);
	assign sts.scan_end  = (scan_q == SW'(NUM_SLOTS - 1));
	assign sts.zone_last = ((z_q + ZCNT_W'(1)) == n_q);
	assign sts.out_free  = !res_valid_q || res.ready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q    <= item.cmd;
			slot_q   <= item.slot;
			zi_q     <= item.zone_index;
			en_q     <= item.enable;
			days_q   <= item.day_mask;
			hour_q   <= item.hour;
			minute_q <= item.minute;
			cnt_q    <= item.zone_count;
			zid_q    <= item.zone_id;
			dur_q    <= item.duration_min;
			stamp_q  <= item.minute_stamp;
			dow_q    <= item.day_of_week;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_en_q[s]    <= 1'b0;
				slot_days_q[s]  <= '0;
				slot_hour_q[s]  <= '0;
				slot_min_q[s]   <= '0;
				slot_zc_q[s]    <= '0;
				slot_stamp_q[s] <= '0;
			end
			zvld_q <= '0;
		end else begin
			if (do_write) begin
				case (cmd_q)
					CMD_HEADER: begin
						slot_en_q[si]   <= en_q;
						slot_days_q[si] <= days_q;
						slot_hour_q[si] <= hour_q;
						slot_min_q[si]  <= minute_q;
						slot_zc_q[si]   <= cnt_sat;
					end
					CMD_ZONE: begin
						zvld_q[waddr] <= 1'b1;
					end
					CMD_CLEAR: begin
						slot_en_q[si]   <= 1'b0;
						slot_days_q[si] <= '0;
						slot_hour_q[si] <= '0;
						slot_min_q[si]  <= '0;
						slot_zc_q[si]   <= '0;
						for (int z = 0; z < ZONES_PER_SLOT; z++) begin
							zvld_q[wbase + ZAW'(z)] <= 1'b0;
						end
					end
					default: begin
						slot_en_q[si] <= !slot_en_q[si];
					end
				endcase
			end
			if (cmd.fire) begin
				slot_stamp_q[scan_q] <= stamp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_write && (cmd_q == CMD_ZONE)) begin
			zid_mem[waddr] <= zid_q;
			dur_mem[waddr] <= dur_q;
		end
		if (cmd.zone_rd) begin
			rd_zid_q <= zid_mem[raddr];
			rd_dur_q <= dur_mem[raddr];
			rd_vld_q <= zvld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			fslot_q <= '0;
			n_q     <= '0;
			z_q     <= '0;
		end else begin
			if (cmd.latch) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + SW'(1);
			end
			if (cmd.fire) begin
				fslot_q <= scan_q;
				n_q     <= slot_zc_q[scan_q];
				z_q     <= '0;
			end else if (cmd.zone_next) begin
				z_q <= z_q + ZCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.put_zone || cmd.put_single) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_zone) begin
			res_status_q <= ST_FIRED;
			res_slot_q   <= fslot_w[FSLOT_W-1:0];
			res_zid_q    <= rd_vld_q ? rd_zid_q : '0;
			res_dur_q    <= rd_vld_q ? rd_dur_q : '0;
			res_last_q   <= sts.zone_last;
		end else if (cmd.put_single) begin
			res_status_q <= rejected ? ST_REJECT : ST_DONE;
			res_slot_q   <= '0;
			res_zid_q    <= '0;
			res_dur_q    <= '0;
			res_last_q   <= 1'b1;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.fired_slot   = res_slot_q;
	assign res.out_zone_id  = res_zid_q;
	assign res.out_duration = res_dur_q;
	assign res.last         = res_last_q;
endmodule

// ===== rtl/weekly_alarm_slot_matcher.sv =====
// Top level of the weekly alarm slot matcher: controller plus datapath.
// Table commands and unused codes: one result, staged through the execute and put states.
// Tick: the scan steps from slot 0 and stops at the first hit; a fire then gives one beat per zone
// of the slot's zone count, each read then staged once the output is free; a miss gives one result.
// One item at a time; the next beat is taken once the previous item's last result is staged.
// Asynchronous reset clears the slot table, stamps and zone valid bits; all slots disabled.
`timescale 1ns / 1ps
module weekly_alarm_slot_matcher import wasm_pkg::*; #(
	parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
	parameter int ZONES_PER_SLOT = ZONES_PER_SLOT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wasm_item_if.sink     item,
	wasm_result_if.source res
);
	wasm_cmd_t cmd;
	wasm_sts_t sts;

	wasm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wasm_dp #(
		.NUM_SLOTS      (NUM_SLOTS),
		.ZONES_PER_SLOT (ZONES_PER_SLOT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the weekly alarm slot matcher: directed and random commands and ticks.
`timescale 1ns / 1ps
module testbench;
	import wasm_pkg::*;

	localparam int SLOTS        = NUM_SLOTS_DEF;
	localparam int ZONES        = ZONES_PER_SLOT_DEF;
	localparam int RANDOM_ITEMS = 160;
	localparam int MAX_WAIT     = 6;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SLOT_TOP     = (1 << SLOT_W) - 1;
	localparam int ZIDX_TOP     = (1 << ZIDX_W) - 1;
	localparam int DOW_TOP      = (1 << DOW_W) - 1;
	localparam int WEEKDAY_TOP  = DAYS_W - 1;
	localparam logic [CMD_W-1:0] CMD_SPARE_TOP = '1;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [SLOT_W-1:0]   slot;
		logic [ZIDX_W-1:0]   zone_index;
		logic                enable;
		logic [DAYS_W-1:0]   day_mask;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [ZCNT_W-1:0]   zone_count;
		logic [ZID_W-1:0]    zone_id;
		logic [DUR_W-1:0]    duration_min;
		logic [STAMP_W-1:0]  minute_stamp;
		logic [DOW_W-1:0]    day_of_week;
	} alarm_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FSLOT_W-1:0]  fired_slot;
		logic [ZID_W-1:0]    zone_id;
		logic [DUR_W-1:0]    duration;
		logic                last;
	} zone_beat_t;

	logic clk;
	logic arst_n;

	wasm_item_if   item_ch ();
	wasm_result_if res_ch ();

	weekly_alarm_slot_matcher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.res    (res_ch)
	);

	// shadow of the slot table
	logic                tbl_enabled [SLOTS];
	logic [DAYS_W-1:0]   tbl_days    [SLOTS];
	logic [HOUR_W-1:0]   tbl_hour    [SLOTS];
	logic [MINUTE_W-1:0] tbl_minute  [SLOTS];
	logic [ZCNT_W-1:0]   tbl_count   [SLOTS];
	logic [STAMP_W-1:0]  fired_stamp [SLOTS];
	logic [ZID_W-1:0]    tbl_zone_id [SLOTS*ZONES];
	logic [DUR_W-1:0]    tbl_zone_dur[SLOTS*ZONES];

	zone_beat_t zone_beats_due[$];

	bit quiet;
	int failures;
	int items_sent;
	int ticks_fired;
	int rejects_seen;
	int beats_checked;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d beats outstanding", $time, cycle_count,
				zone_beats_due.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic zone_beat_t make_beat(logic [STATUS_W-1:0] st, int s, logic [ZID_W-1:0] zid,
		logic [DUR_W-1:0] dur, logic lst);
		zone_beat_t b;
		b.status     = st;
		b.fired_slot = FSLOT_W'(s);
		b.zone_id    = zid;
		b.duration   = dur;
		b.last       = lst;
		return b;
	endfunction

	function automatic bit slot_matches(int s, alarm_item_t it);
		if (!tbl_enabled[s] || tbl_count[s] == '0)
			return 1'b0;
		if (it.day_of_week > WEEKDAY_TOP)
			return 1'b0;
		if (!tbl_days[s][it.day_of_week])
			return 1'b0;
		return tbl_hour[s] == it.hour && tbl_minute[s] == it.minute;
	endfunction

	task automatic predict_response(input alarm_item_t it);
		int s, z, n, base;
		bit hit;
		hit = 1'b0;
		if (it.cmd == CMD_TICK) begin
			for (s = 0; s < SLOTS && !hit; s++) begin
				if (slot_matches(s, it) && fired_stamp[s] != it.minute_stamp) begin
					hit = 1'b1;
					ticks_fired++;
					fired_stamp[s] = it.minute_stamp;
					n = int'(tbl_count[s]);
					for (z = 0; z < n; z++)
						zone_beats_due.push_back(make_beat(ST_FIRED, s, tbl_zone_id[s*ZONES+z],
							tbl_zone_dur[s*ZONES+z], z == n - 1));
				end
			end
			if (!hit)
				zone_beats_due.push_back(make_beat(ST_DONE, 0, '0, '0, 1'b1));
		end else if (it.cmd > CMD_TOGGLE) begin
			zone_beats_due.push_back(make_beat(ST_DONE, 0, '0, '0, 1'b1));
		end else if (it.slot >= SLOTS || (it.cmd == CMD_ZONE && it.zone_index >= ZONES)) begin
			rejects_seen++;
			zone_beats_due.push_back(make_beat(ST_REJECT, 0, '0, '0, 1'b1));
		end else begin
			s = int'(it.slot);
			base = s * ZONES;
			case (it.cmd)
				CMD_HEADER: begin
					tbl_enabled[s] = it.enable;
					tbl_days[s]    = it.day_mask;
					tbl_hour[s]    = it.hour;
					tbl_minute[s]  = it.minute;
					tbl_count[s]   = (it.zone_count > ZONES) ? ZCNT_W'(ZONES) : it.zone_count;
				end
				CMD_ZONE: begin
					tbl_zone_id[base + int'(it.zone_index)]  = it.zone_id;
					tbl_zone_dur[base + int'(it.zone_index)] = it.duration_min;
				end
				CMD_CLEAR: begin
					tbl_enabled[s] = 1'b0;
					tbl_days[s]    = '0;
					tbl_hour[s]    = '0;
					tbl_minute[s]  = '0;
					tbl_count[s]   = '0;
					for (z = 0; z < ZONES; z++) begin
						tbl_zone_id[base + z]  = '0;
						tbl_zone_dur[base + z] = '0;
					end
				end
				default: tbl_enabled[s] = ~tbl_enabled[s];
			endcase
			zone_beats_due.push_back(make_beat(ST_DONE, 0, '0, '0, 1'b1));
		end
	endtask

	task automatic drive_item(input alarm_item_t it);
		item_ch.cmd          <= it.cmd;
		item_ch.slot         <= it.slot;
		item_ch.zone_index   <= it.zone_index;
		item_ch.enable       <= it.enable;
		item_ch.day_mask     <= it.day_mask;
		item_ch.hour         <= it.hour;
		item_ch.minute       <= it.minute;
		item_ch.zone_count   <= it.zone_count;
		item_ch.zone_id      <= it.zone_id;
		item_ch.duration_min <= it.duration_min;
		item_ch.minute_stamp <= it.minute_stamp;
		item_ch.day_of_week  <= it.day_of_week;
	endtask

	task automatic send_item(input alarm_item_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		drive_item(it);
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		predict_response(it);
		items_sent++;
	endtask

	function automatic alarm_item_t slot_item(logic [CMD_W-1:0] c, int s);
		alarm_item_t it;
		it      = '0;
		it.cmd  = c;
		it.slot = SLOT_W'(s);
		return it;
	endfunction

	function automatic alarm_item_t header_item(int s, logic en, logic [DAYS_W-1:0] days,
		logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m, logic [ZCNT_W-1:0] cnt);
		alarm_item_t it;
		it            = slot_item(CMD_HEADER, s);
		it.enable     = en;
		it.day_mask   = days;
		it.hour       = h;
		it.minute     = m;
		it.zone_count = cnt;
		return it;
	endfunction

	function automatic alarm_item_t zone_item(int s, int zi, logic [ZID_W-1:0] zid,
		logic [DUR_W-1:0] dur);
		alarm_item_t it;
		it              = slot_item(CMD_ZONE, s);
		it.zone_index   = ZIDX_W'(zi);
		it.zone_id      = zid;
		it.duration_min = dur;
		return it;
	endfunction

	function automatic alarm_item_t tick_item(int dow, logic [HOUR_W-1:0] h,
		logic [MINUTE_W-1:0] m, logic [STAMP_W-1:0] stamp);
		alarm_item_t it;
		it              = slot_item(CMD_TICK, 0);
		it.day_of_week  = DOW_W'(dow);
		it.hour         = h;
		it.minute       = m;
		it.minute_stamp = stamp;
		return it;
	endfunction

	function automatic int pick_slot();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(SLOTS, SLOT_TOP)
			: $urandom_range(0, SLOTS - 1);
	endfunction

	// result side: random back-pressure per beat
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	always @(posedge clk) begin
		zone_beat_t got, want;
		if (res_ch.valid && res_ch.ready) begin
			got.status     = res_ch.status;
			got.fired_slot = res_ch.fired_slot;
			got.zone_id    = res_ch.out_zone_id;
			got.duration   = res_ch.out_duration;
			got.last       = res_ch.last;
			if (zone_beats_due.size() == 0) begin
				failures++;
				$display("%0t unexpected beat: expected none, actual st=%0d slot=%0d zone=%0d dur=%0d last=%0d",
					$time, got.status, got.fired_slot, got.zone_id, got.duration, got.last);
			end else begin
				want = zone_beats_due.pop_front();
				beats_checked++;
				if (got !== want) begin
					failures++;
					$display("%0t mismatch: expected st=%0d slot=%0d zone=%0d dur=%0d last=%0d",
						$time, want.status, want.fired_slot, want.zone_id, want.duration, want.last);
					$display("%0t          actual   st=%0d slot=%0d zone=%0d dur=%0d last=%0d",
						$time, got.status, got.fired_slot, got.zone_id, got.duration, got.last);
				end
			end
		end
	end

	task automatic test_bad_indices();
		int c;
		send_item(header_item(SLOTS, 1'b1, '1, '0, '0, 3'd1));
		send_item(header_item(SLOT_TOP, 1'b1, '1, '0, '0, 3'd1));
		send_item(zone_item(0, ZONES, 8'hAA, 16'h1234));
		send_item(zone_item(0, ZIDX_TOP, 8'h55, 16'h4321));
		send_item(slot_item(CMD_CLEAR, SLOTS + 1));
		send_item(slot_item(CMD_TOGGLE, SLOT_TOP));
		for (c = CMD_TOGGLE + 1; c <= CMD_SPARE_TOP; c++)
			send_item(slot_item(CMD_W'(c), SLOT_TOP));
	endtask

	task automatic test_first_slot_fire();
		int z;
		// count above the maximum saturates
		send_item(header_item(0, 1'b1, '1, 5'd23, 6'd59, '1));
		for (z = 0; z < ZONES; z++)
			send_item(zone_item(0, z, z[0] ? 8'h00 : 8'hFF, z[0] ? 16'hFFFF : 16'h0000));
		send_item(tick_item(WEEKDAY_TOP, 5'd23, 6'd59, '1));
		// same stamp again: already fired
		send_item(tick_item(WEEKDAY_TOP, 5'd23, 6'd59, '1));
		send_item(slot_item(CMD_CLEAR, 0));
	endtask

	task automatic test_odd_times();
		send_item(header_item(SLOTS - 1, 1'b1, 7'h01, '1, '1, 3'd1));
		send_item(tick_item(0, '1, '1, '0));
		send_item(tick_item(0, '1, '1, 32'd5));
		send_item(tick_item(DOW_TOP, '1, '1, 32'd6));
		send_item(slot_item(CMD_TOGGLE, SLOTS - 1));
		send_item(tick_item(0, '1, '1, 32'd7));
	endtask

	task automatic test_random_schedules(input int n);
		alarm_item_t it;
		logic [95:0] noise;
		logic [STAMP_W-1:0] stamp;
		int k, pick, s;
		for (k = 0; k < n; k++) begin
			quiet = (k >= n / 3) && (k < n / 2);
			pick = $urandom_range(0, 99);
			s = $urandom_range(0, SLOTS - 1);
			if (pick < 40) begin
				// aim at a stored start time, sometimes repeating its last stamp
				stamp = ($urandom_range(0, 4) == 0) ? fired_stamp[s] : $urandom;
				it = tick_item($urandom_range(0, DOW_TOP), tbl_hour[s], tbl_minute[s], stamp);
			end else if (pick < 55) begin
				it = header_item(pick_slot(), $urandom_range(0, 3) != 0,
					DAYS_W'($urandom_range(0, 127)), HOUR_W'($urandom_range(0, 31)),
					MINUTE_W'($urandom_range(0, 63)), ZCNT_W'($urandom_range(0, 7)));
			end else if (pick < 75) begin
				it = zone_item(pick_slot(), ($urandom_range(0, 7) == 0) ? $urandom_range(0, ZIDX_TOP)
					: $urandom_range(0, ZONES - 1), ZID_W'($urandom_range(0, 255)),
					DUR_W'($urandom_range(0, 65535)));
			end else if (pick < 80) begin
				it = slot_item(CMD_CLEAR, pick_slot());
			end else if (pick < 85) begin
				it = slot_item(CMD_TOGGLE, pick_slot());
			end else begin
				noise = {$urandom, $urandom, $urandom};
				it = noise[$bits(alarm_item_t)-1:0];
			end
			send_item(it);
		end
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause();
		item_ch.valid <= 1'b0;
		while (zone_beats_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		alarm_item_t idle;
		idle = '0;
		quiet = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_enabled[i] = 1'b0;
			tbl_days[i]    = '0;
			tbl_hour[i]    = '0;
			tbl_minute[i]  = '0;
			tbl_count[i]   = '0;
			fired_stamp[i] = '0;
		end
		for (int i = 0; i < SLOTS * ZONES; i++) begin
			tbl_zone_id[i]  = '0;
			tbl_zone_dur[i] = '0;
		end
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		drive_item(idle);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_indices();
		test_first_slot_fire();
		test_odd_times();
		test_random_schedules(RANDOM_ITEMS / 2);
		test_drain_pause();
		test_random_schedules(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		item_ch.valid <= 1'b0;
		while (zone_beats_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d commands and ticks, %0d ticks fired a slot, %0d index rejects.",
			items_sent, ticks_fired, rejects_seen);
		$display("Compared %0d result beats, %0d failures.", beats_checked, failures);
		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
